// File: design/imq_pkg.sv
`timescale 1ns / 1ps
package imq_pkg;
    localparam int NUM_VERTICES = 256;
    localparam int PRIORITY_WIDTH = 32;
    localparam int SLOT_W = $clog2(NUM_VERTICES);
    localparam int CNT_W = SLOT_W + 1;
    localparam int VID_W = 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef struct packed {
        logic                      opcode;
        logic [VID_W-1:0]          vertex_id;
        logic [31:0]               priority_req;
    } imq_req_t;

    typedef struct packed {
        logic                      status;
        logic [VID_W-1:0]          removed_vertex;
        logic [31:0]               removed_priority;
        logic [8:0]                count;
    } imq_rsp_t;

    typedef struct packed {
        logic                      we;
        logic [SLOT_W-1:0]         waddr;
        logic [VID_W-1:0]          wvert;
        logic [PRIORITY_WIDTH-1:0] wprio;
        logic [SLOT_W-1:0]         raddr;
    } imq_heap_cmd_t;

    typedef struct packed {
        logic [VID_W-1:0]          vert;
        logic [PRIORITY_WIDTH-1:0] prio;
    } imq_entry_t;
endpackage

// File: design/imq_heap_mem.sv
`timescale 1ns / 1ps
module imq_heap_mem
(
    input  logic                 clk,
    input  imq_pkg::imq_heap_cmd_t cmd,
    output imq_pkg::imq_entry_t  rdata
);
    import imq_pkg::*;

    imq_entry_t mem [NUM_VERTICES];

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.waddr] <= '{vert: cmd.wvert, prio: cmd.wprio};
        end
        rdata <= mem[cmd.raddr];
    end
endmodule

// File: design/imq_pos_mem.sv
`timescale 1ns / 1ps
module imq_pos_mem
(
    input  logic                      clk,
    input  logic                      we,
    input  logic [imq_pkg::VID_W-1:0]  waddr,
    input  logic [imq_pkg::SLOT_W-1:0] wdata,
    input  logic [imq_pkg::VID_W-1:0]  raddr,
    output logic [imq_pkg::SLOT_W-1:0] rdata
);
    import imq_pkg::*;

    logic [SLOT_W-1:0] mem [NUM_VERTICES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: design/indexed_min_priority_queue_top.sv
`timescale 1ns / 1ps
// An insert of a new vertex climbs level by level; decrease-key first looks up the vertex's slot and priority.
// Remove reads the root and the last entry, then descends level by level; 256 slots give at most 8 levels.
// One transfer at a time; busy rises once start is taken and stays high through the result strobe cycle.
// Each climb level is one parent read and compare; each descent level reads both children.
// Reset clears the count and every vertex's queued flag; the memories are not cleared.
// The result is shown for one cycle on done and the receiver cannot stall it.
module indexed_min_priority_queue_top
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  imq_pkg::imq_req_t req,
    output logic              busy,
    output logic              done,
    output imq_pkg::imq_rsp_t rsp
);
    import imq_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PWAIT = 4'd2;
    localparam logic [3:0] S_CUR   = 4'd3;
    localparam logic [3:0] S_UPRD  = 4'd4;
    localparam logic [3:0] S_UPCMP = 4'd5;
    localparam logic [3:0] S_ROOT  = 4'd6;
    localparam logic [3:0] S_LAST  = 4'd7;
    localparam logic [3:0] S_DNL   = 4'd8;
    localparam logic [3:0] S_DNR   = 4'd9;
    localparam logic [3:0] S_DNCMP = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;
    localparam logic [3:0] S_DNW   = 4'd12;

    logic [3:0]                state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [NUM_VERTICES-1:0]   valid_reg, valid_next;
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic [SLOT_W-1:0]         child_reg, child_next;
    logic [VID_W-1:0]          cvert_reg, cvert_next;
    logic [PRIORITY_WIDTH-1:0] cprio_reg, cprio_next;
    logic [VID_W-1:0]          lvert_reg, lvert_next;
    logic [PRIORITY_WIDTH-1:0] lprio_reg, lprio_next;
    logic [VID_W-1:0]          rvert_reg, rvert_next;
    logic [PRIORITY_WIDTH-1:0] rprio_reg, rprio_next;
    logic                      stat_reg, stat_next;
    logic                      done_reg, done_next;
    logic                      rchild_reg, rchild_next;

    imq_heap_cmd_t             hcmd;
    imq_entry_t                hrd;
    logic                      pwe;
    logic [VID_W-1:0]          pwaddr, praddr;
    logic [SLOT_W-1:0]         pwdata, prd;
    logic [SLOT_W-1:0]         parent;
    logic [CNT_W:0]            lidx, ridx;
    logic [PRIORITY_WIDTH-1:0] reqp;

    imq_heap_mem u_heap (.clk(clk), .cmd(hcmd), .rdata(hrd));
    imq_pos_mem u_pos (.clk(clk), .we(pwe), .waddr(pwaddr), .wdata(pwdata),
                       .raddr(praddr), .rdata(prd));

    assign parent = (slot_reg - SLOT_W'(1)) >> 1;
    assign lidx = {slot_reg, 1'b1} + (CNT_W+1)'(0);
    assign ridx = lidx + (CNT_W+1)'(1);
    assign reqp = PRIORITY_WIDTH'(req.priority_req);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        valid_next  = valid_reg;
        slot_next   = slot_reg;
        child_next  = child_reg;
        cvert_next  = cvert_reg;
        cprio_next  = cprio_reg;
        lvert_next  = lvert_reg;
        lprio_next  = lprio_reg;
        rvert_next  = rvert_reg;
        rprio_next  = rprio_reg;
        stat_next   = stat_reg;
        rchild_next = rchild_reg;
        done_next   = 1'b0;
        hcmd        = '{we: 1'b0, waddr: slot_reg, wvert: cvert_reg,
                        wprio: cprio_reg, raddr: slot_reg};
        pwe         = 1'b0;
        pwaddr      = cvert_reg;
        pwdata      = slot_reg;
        praddr      = req.vertex_id;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && !done_reg)
                begin
                    stat_next  = 1'b0;
                    rvert_next = '0;
                    rprio_next = '0;
                    cvert_next = req.vertex_id;
                    cprio_next = reqp;
                    if (req.opcode == OP_INSERT)
                    begin
                        if (valid_reg[req.vertex_id])
                        begin
                            state_next = S_PWAIT;
                        end
                        else if (count_reg < CNT_W'(NUM_VERTICES))
                        begin
                            slot_next = count_reg[SLOT_W-1:0];
                            count_next = count_reg + CNT_W'(1);
                            valid_next[req.vertex_id] = 1'b1;
                            state_next = S_UPRD;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        stat_next  = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        hcmd.raddr = '0;
                        state_next = S_ROOT;
                    end
                end
            end
            S_PWAIT:
            begin
                slot_next  = prd;
                hcmd.raddr = prd;
                state_next = S_CUR;
            end
            S_CUR:
            begin
                if (cprio_reg < hrd.prio)
                begin
                    state_next = S_UPRD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_UPRD:
            begin
                if (slot_reg == '0)
                begin
                    hcmd.we = 1'b1;
                    pwe = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    hcmd.raddr = parent;
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP:
            begin
                if (cprio_reg < hrd.prio)
                begin
                    hcmd.we = 1'b1;
                    hcmd.wvert = hrd.vert;
                    hcmd.wprio = hrd.prio;
                    pwe = 1'b1;
                    pwaddr = hrd.vert;
                    slot_next = parent;
                    state_next = S_UPRD;
                end
                else
                begin
                    hcmd.we = 1'b1;
                    pwe = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_ROOT:
            begin
                rvert_next = hrd.vert;
                rprio_next = hrd.prio;
                valid_next[hrd.vert] = 1'b0;
                count_next = count_reg - CNT_W'(1);
                hcmd.raddr = SLOT_W'(count_reg - CNT_W'(1));
                slot_next = '0;
                if (count_reg == CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                cvert_next = hrd.vert;
                cprio_next = hrd.prio;
                state_next = S_DNL;
            end
            S_DNL:
            begin
                if (lidx < (CNT_W+1)'(count_reg))
                begin
                    hcmd.raddr = lidx[SLOT_W-1:0];
                    rchild_next = (ridx < (CNT_W+1)'(count_reg));
                    state_next = S_DNR;
                end
                else
                begin
                    state_next = S_DNW;
                end
            end
            S_DNR:
            begin
                lvert_next = hrd.vert;
                lprio_next = hrd.prio;
                child_next = lidx[SLOT_W-1:0];
                hcmd.raddr = ridx[SLOT_W-1:0];
                state_next = S_DNCMP;
            end
            S_DNCMP:
            begin
                if (rchild_reg && (hrd.prio < lprio_reg))
                begin
                    if (cprio_reg <= hrd.prio)
                    begin
                        state_next = S_DNW;
                    end
                    else
                    begin
                        hcmd.we = 1'b1;
                        hcmd.wvert = hrd.vert;
                        hcmd.wprio = hrd.prio;
                        pwe = 1'b1;
                        pwaddr = hrd.vert;
                        slot_next = ridx[SLOT_W-1:0];
                        state_next = S_DNL;
                    end
                end
                else if (cprio_reg <= lprio_reg)
                begin
                    state_next = S_DNW;
                end
                else
                begin
                    hcmd.we = 1'b1;
                    hcmd.wvert = lvert_reg;
                    hcmd.wprio = lprio_reg;
                    pwe = 1'b1;
                    pwaddr = lvert_reg;
                    slot_next = child_reg;
                    state_next = S_DNL;
                end
            end
            S_DNW:
            begin
                hcmd.we = 1'b1;
                pwe = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        child_reg  <= child_next;
        cvert_reg  <= cvert_next;
        cprio_reg  <= cprio_next;
        lvert_reg  <= lvert_next;
        lprio_reg  <= lprio_next;
        rvert_reg  <= rvert_next;
        rprio_reg  <= rprio_next;
        stat_reg   <= stat_next;
        rchild_reg <= rchild_next;
    end

    assign busy = (state_reg != S_IDLE) || done_reg;
    assign done = done_reg;
    assign rsp  = '{status: stat_reg, removed_vertex: rvert_reg,
                    removed_priority: 32'(rprio_reg), count: 9'(count_reg)};

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(NUM_VERTICES))
        else $error("queue count exceeds capacity");
    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($countones(valid_reg) == int'(count_reg)))
        else $error("queued flags disagree with count");
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && stat_reg) |-> (count_reg == '0))
        else $error("empty flag with nonzero count");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");
`endif
endmodule

// File: tb/sv/indexed_min_priority_queue_checker.sv
`timescale 1ns / 1ps
module indexed_min_priority_queue_checker
    import imq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  imq_req_t req,
    input  logic     done,
    input  imq_rsp_t rsp,
    output int       errors,
    output int       pending
);
    logic [VID_W-1:0]          heap_vert [NUM_VERTICES];
    logic [PRIORITY_WIDTH-1:0] heap_prio [NUM_VERTICES];
    int                        slot_of   [NUM_VERTICES];
    bit                        queued    [NUM_VERTICES];
    int                        heap_size;
    imq_rsp_t                  expected_rsp_q[$];

    assign pending = expected_rsp_q.size();

    function automatic void swap_slots(int a, int b);
        logic [VID_W-1:0]          v;
        logic [PRIORITY_WIDTH-1:0] p;
        v = heap_vert[a];
        p = heap_prio[a];
        heap_vert[a] = heap_vert[b];
        heap_prio[a] = heap_prio[b];
        heap_vert[b] = v;
        heap_prio[b] = p;
        slot_of[heap_vert[a]] = a;
        slot_of[heap_vert[b]] = b;
    endfunction

    function automatic void climb(int s);
        int parent;
        while (s > 0)
        begin
            parent = (s - 1) / 2;
            if (!(heap_prio[s] < heap_prio[parent]))
                break;
            swap_slots(s, parent);
            s = parent;
        end
    endfunction

    function automatic void descend(int s);
        int child;
        while (2 * s + 1 < heap_size)
        begin
            child = 2 * s + 1;
            if (child + 1 < heap_size && heap_prio[child + 1] < heap_prio[child])
                child++;
            if (heap_prio[s] <= heap_prio[child])
                break;
            swap_slots(s, child);
            s = child;
        end
    endfunction

    function automatic imq_rsp_t apply_request(imq_req_t r);
        imq_rsp_t o;
        int       v;
        int       s;
        o = '0;
        v = r.vertex_id;
        if (r.opcode == OP_INSERT)
        begin
            if (queued[v])
            begin
                s = slot_of[v];
                if (r.priority_req < heap_prio[s])
                begin
                    heap_prio[s] = r.priority_req;
                    climb(s);
                end
            end
            else if (heap_size < NUM_VERTICES)
            begin
                s = heap_size;
                heap_vert[s] = r.vertex_id;
                heap_prio[s] = r.priority_req;
                slot_of[v] = s;
                queued[v] = 1'b1;
                heap_size++;
                climb(s);
            end
        end
        else if (heap_size == 0)
        begin
            o.status = 1'b1;
        end
        else
        begin
            o.removed_vertex = heap_vert[0];
            o.removed_priority = heap_prio[0];
            queued[heap_vert[0]] = 1'b0;
            heap_vert[0] = heap_vert[heap_size - 1];
            heap_prio[0] = heap_prio[heap_size - 1];
            heap_size--;
            if (heap_size > 0)
            begin
                slot_of[heap_vert[0]] = 0;
                descend(0);
            end
        end
        o.count = 9'(heap_size);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        imq_rsp_t e;
        if (!rst_n)
        begin
            errors = 0;
            heap_size = 0;
            foreach (queued[i])
                queued[i] = 1'b0;
            expected_rsp_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %p", $time, rsp);
                end
                else
                begin
                    e = expected_rsp_q.pop_front();
                    if (e !== rsp)
                    begin
                        errors++;
                        $display("%0t: mismatch expected %p actual %p", $time, e, rsp);
                    end
                end
            end
            if (start && !busy)
                expected_rsp_q.push_back(apply_request(req));
        end
    end
endmodule

// File: tb/sv/indexed_min_priority_queue_top_tb.sv
`timescale 1ns / 1ps
module indexed_min_priority_queue_top_tb;
    import imq_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     start;
    imq_req_t req;
    logic     busy;
    logic     done;
    imq_rsp_t rsp;
    int       errors;
    int       pending;
    int       idle_pct;

    indexed_min_priority_queue_top i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    indexed_min_priority_queue_checker i_checker
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .rsp     (rsp),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    task automatic send(logic op, logic [7:0] vid, logic [31:0] prio);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req <= '{opcode: op, vertex_id: vid, priority_req: prio};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        start <= 1'b0;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_prio();
        case ($urandom_range(3))
            0: return 32'($urandom_range(15));
            1: return 32'hFFFF_FFF0 | 32'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int n;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        idle_pct = 0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(OP_REMOVE, 8'hA5, 32'h1234);
        send(OP_INSERT, 8'd0, 32'hFFFF_FFFF);
        send(OP_INSERT, 8'd255, 32'd0);
        send(OP_INSERT, 8'd7, 32'd0);
        send(OP_INSERT, 8'd9, 32'd100);
        send(OP_INSERT, 8'd9, 32'd200);
        send(OP_INSERT, 8'd9, 32'd100);
        send(OP_INSERT, 8'd0, 32'd50);
        send(OP_INSERT, 8'hAA, 32'hAAAA_AAAA);
        send(OP_INSERT, 8'h55, 32'h5555_5555);
        repeat (8)
            send(OP_REMOVE, 8'h00, 32'h0);

        // Fill the heap completely, then drain it.
        for (int v = 0; v < NUM_VERTICES; v++)
            send(OP_INSERT, v[7:0], rand_prio());
        send(OP_INSERT, 8'd3, 32'd0);
        for (int v = 0; v < NUM_VERTICES + 1; v++)
            send(OP_REMOVE, 8'(v), $urandom);

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 0) ? 0 : (ph == 1) ? 47 : (ph == 2) ? 13 : 0;
            n = 0;
            while (n < 60)
            begin
                if ($urandom_range(99) < 55)
                    send(OP_INSERT, 8'($urandom_range(ph == 3 ? 255 : 31)), rand_prio());
                else
                    send(OP_REMOVE, 8'($urandom), $urandom);
                n++;
            end
        end

        while (pending != 0)
            @(posedge clk);
        repeat (50)
            @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule

// File: files.f
design/imq_pkg.sv
design/imq_heap_mem.sv
design/imq_pos_mem.sv
design/indexed_min_priority_queue_top.sv
tb/sv/indexed_min_priority_queue_checker.sv
tb/sv/indexed_min_priority_queue_top_tb.sv
